[src/tsb_pkg.sv]
// shared types and constants for the timer slot bank
package tsb_pkg;

  // bank size and derived widths
  localparam int unsigned TIMERS = 16;
  localparam int unsigned IDX_W  = (TIMERS > 1) ? $clog2(TIMERS) : 1;
  localparam int unsigned CNT_W  = $clog2(TIMERS + 1);
  localparam int unsigned TIME_W = 64;

  // field widths
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned ADDR_W  = 3;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned RD_W    = 5;
  localparam int unsigned TIDX_W  = 4;
  localparam int unsigned S_TDATA_W = 40;
  localparam int unsigned M_TDATA_W = 16;

  // command codes
  localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd2;

  // register index of the count / arm register
  localparam logic [ADDR_W-1:0] ARM_REG = 3'd7;

  // sequencer states
  typedef enum logic {
    ST_IDLE,
    ST_EVAL
  } state_e;

  // broadcast control from the sequencer to every cell
  typedef struct packed {
    logic              fire_en;
    logic              arm_en;
    logic              reuse_any;
    logic [CNT_W-1:0]  count;
    logic [TIME_W-1:0] now;
    logic [TIME_W-1:0] arm_end;
  } cell_ctl_t;

  // link handed from one cell to the next
  typedef struct packed {
    logic             fire;
    logic             free;
    logic [IDX_W-1:0] fire_idx;
  } cell_link_t;

endpackage

[src/timer_slot_bank_irq.sv]
// top level of the timer slot bank: beat capture, sequencer, cell row, result register
//
//   channel | dir | tdata (low bit up)                  | tuser
//   s_axis  | in  | addr, wr_data, intr_busy, pad to 40 | cmd
//   m_axis  | out | rd_data, irq, irq_timer, no_slot,   | -
//           |     | pad to 16                           |
//
// each beat is captured, then evaluated in one pass along the row of slot cells,
// where the compares run in parallel and the pick ripples through the cells.
// reset zeroes the millisecond counter and slot count and marks every slot done;
// end times are loaded on arm. a result waiting on m_axis does not stop the next
// capture; the evaluate step holds while the result register is still occupied.
module timer_slot_bank_irq (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // addr[2:0], wr_data[34:3], intr_busy[35], zero[39:36]
  input  logic [tsb_pkg::S_TDATA_W-1:0]      s_axis_tdata,
  // cmd[1:0]
  input  logic [tsb_pkg::CMD_W-1:0]          s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // rd_data[4:0], irq[5], irq_timer[9:6], no_slot[10], zero[15:11]
  output logic [tsb_pkg::M_TDATA_W-1:0]      m_axis_tdata
);
  import tsb_pkg::*;

  state_e            state_q, state_d;
  logic              s_beat;
  logic              eval_go;
  logic              out_free;

  logic [CMD_W-1:0]  cmd_q;
  logic [ADDR_W-1:0] addr_q;
  logic              busy_q;
  logic [TIME_W-1:0] arm_end_q;
  logic [TIME_W-1:0] now_q;
  logic [CNT_W-1:0]  count_q;

  logic              out_valid_q;
  logic [M_TDATA_W-1:0] out_data_q, out_data_d;

  logic              is_tick;
  logic              is_arm;
  logic              is_rd7;
  logic              append_ok;

  cell_ctl_t         ctl;
  cell_link_t        link [TIMERS+1];

  assign s_beat   = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;

  // decode of the captured beat
  assign is_tick   = (cmd_q == CMD_TICK);
  assign is_arm    = (cmd_q == CMD_WRITE) && (addr_q == ARM_REG);
  assign is_rd7    = (cmd_q == CMD_READ) && (addr_q == ARM_REG);
  assign append_ok = (count_q < CNT_W'(TIMERS));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_beat) state_d = ST_EVAL;
      end
      ST_EVAL: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    s_axis_tready = 1'b0;
    eval_go       = 1'b0;
    unique case (state_q)
      ST_IDLE: s_axis_tready = 1'b1;
      ST_EVAL: eval_go       = out_free;
      default: s_axis_tready = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // beat capture
  always_ff @(posedge clk_i) begin
    if (s_beat) begin
      cmd_q     <= s_axis_tuser;
      addr_q    <= s_axis_tdata[ADDR_W-1:0];
      busy_q    <= s_axis_tdata[ADDR_W+DATA_W];
      arm_end_q <= now_q + TIME_W'(s_axis_tdata[ADDR_W+DATA_W-1:ADDR_W]);
    end
  end

  // millisecond counter, stepped at capture of a tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      now_q <= '0;
    end else if (s_beat && (s_axis_tuser == CMD_TICK)) begin
      now_q <= now_q + TIME_W'(1);
    end
  end

  // broadcast to the cells
  always_comb begin
    ctl.fire_en   = eval_go && is_tick && !busy_q;
    ctl.arm_en    = eval_go && is_arm && (link[TIMERS].free || append_ok);
    ctl.reuse_any = link[TIMERS].free;
    ctl.count     = count_q;
    ctl.now       = now_q;
    ctl.arm_end   = arm_end_q;
  end

  assign link[0] = '0;

  // row of slot cells
  for (genvar g = 0; g < TIMERS; g++) begin : g_cell
    tsb_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .idx_i  (CNT_W'(g)),
      .ctl_i  (ctl),
      .link_i (link[g]),
      .link_o (link[g+1])
    );
  end

  // slot count grows on append
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (ctl.arm_en && !link[TIMERS].free) begin
      count_q <= count_q + CNT_W'(1);
    end
  end

  // result beat
  always_comb begin
    out_data_d = '0;
    if (is_rd7) begin
      out_data_d[RD_W-1:0] = RD_W'(count_q);
    end
    if (ctl.fire_en && link[TIMERS].fire) begin
      out_data_d[RD_W] = 1'b1;
      out_data_d[RD_W+TIDX_W:RD_W+1] = TIDX_W'(link[TIMERS].fire_idx);
    end
    out_data_d[RD_W+TIDX_W+1] = is_arm && !link[TIMERS].free && !append_ok;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (eval_go) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (eval_go) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

[src/tsb_cell.sv]
// one timer slot: end time, done flag and its stage of the priority chains
module tsb_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [tsb_pkg::CNT_W-1:0] idx_i,
  input  tsb_pkg::cell_ctl_t        ctl_i,
  input  tsb_pkg::cell_link_t       link_i,
  output tsb_pkg::cell_link_t       link_o
);
  import tsb_pkg::*;

  logic [TIME_W-1:0] end_q;
  logic              done_q;
  logic              in_use;
  logic              expired;
  logic              free_here;
  logic              take_fire;
  logic              take_arm;

  // local tests on this slot
  assign in_use    = idx_i < ctl_i.count;
  assign expired   = in_use && !done_q && (ctl_i.now >= end_q);
  assign free_here = in_use && done_q;

  // claim only when no lower slot claimed first
  assign take_fire = ctl_i.fire_en && expired && !link_i.fire;
  assign take_arm  = ctl_i.arm_en &&
                     ((free_here && !link_i.free) ||
                      (!ctl_i.reuse_any && (idx_i == ctl_i.count)));

  // hand the chains on to the next cell
  always_comb begin
    link_o.fire     = link_i.fire | expired;
    link_o.free     = link_i.free | free_here;
    link_o.fire_idx = link_i.fire ? link_i.fire_idx : idx_i[IDX_W-1:0];
  end

  // done flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b1;
    end else if (take_arm) begin
      done_q <= 1'b0;
    end else if (take_fire) begin
      done_q <= 1'b1;
    end
  end

  // end time, written on arm only
  always_ff @(posedge clk_i) begin
    if (take_arm) begin
      end_q <= ctl_i.arm_end;
    end
  end

endmodule
